@@ sv/u8u16_pkg.sv @@
package u8u16_pkg;

    typedef logic [2:0]  len_t;
    typedef logic [20:0] cp_t;
    typedef logic [15:0] unit_t;
    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  count_t;

    localparam unit_t REPL_CHAR   = 16'hfffd;
    localparam cp_t   SUPP_BASE   = 21'h010000;
    localparam cp_t   MAX_CP      = 21'h10ffff;
    localparam logic [5:0] HI_SURR_TOP = 6'b110110;
    localparam logic [5:0] LO_SURR_TOP = 6'b110111;

    localparam len_t UPPER_LEN [16] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd0
    };

    // sequence length from the lead byte, zero for an invalid lead
    function automatic len_t seq_len(input byte_t lead);
        len_t len;
        if (!lead[7])
        begin
            len = 3'd1;
        end
        else
        begin
            len = UPPER_LEN[lead[6:3]];
        end
        return len;
    endfunction

    // code point of a complete sequence, continuation bytes masked only
    function automatic cp_t decode_cp(input len_t len, input byte_t b0, input byte_t b1,
                                      input byte_t b2, input byte_t b3);
        cp_t cp;
        case (len)
            3'd1:    cp = {14'd0, b0[6:0]};
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = '0;
        endcase
        return cp;
    endfunction

endpackage

@@ sv/utf8_to_utf16_transcoder_top.sv @@
// the first code unit of a byte is offered in the cycle after the byte is taken
// throughput: one byte per cycle while each byte gives at most one unit and unit_stall is low; a
// byte that gives more units holds the input until the three-entry result register, which
// drains one unit per cycle while unit_stall is low, is down to its last unit
// reset: asynchronous, clears the sequence count, length, result count and final flag;
// buffered sequence bytes and result entries are not reset
module utf8_to_utf16_transcoder_top
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        is_final_byte,
    output logic        unit_valid,
    input  logic        unit_stall,
    output logic [15:0] code_unit,
    output logic        last_of_run,
    output logic        end_of_text
);

    byte_t  pend_reg [3];
    count_t pend_cnt_reg;
    count_t pend_cnt_next;
    len_t   exp_len_reg;
    len_t   exp_len_next;

    unit_t  res_reg [3];
    count_t res_cnt_reg;
    logic   res_final_reg;

    logic   in_take;
    logic   out_take;
    logic   buffer_byte;

    byte_t  b0;
    byte_t  b1;
    byte_t  b2;
    len_t   n;
    len_t   len0;
    logic   full0;
    cp_t    cp0;
    cp_t    cp_fix;
    cp_t    cp_off;
    unit_t  u0;
    unit_t  u1;
    unit_t  u2;
    count_t num;

    assign out_take   = unit_valid && !unit_stall;
    assign byte_stall = !((res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && !unit_stall));
    assign in_take    = byte_valid && !byte_stall;

    assign unit_valid  = (res_cnt_reg != 2'd0);
    assign code_unit   = res_reg[0];
    assign last_of_run = (res_cnt_reg == 2'd1);
    assign end_of_text = res_final_reg && (res_cnt_reg == 2'd1);

    // sequence so far, with the new byte in the slot after the buffered ones
    assign b0 = (pend_cnt_reg == 2'd0) ? data_byte : pend_reg[0];
    assign b1 = (pend_cnt_reg == 2'd1) ? data_byte : pend_reg[1];
    assign b2 = (pend_cnt_reg == 2'd2) ? data_byte : pend_reg[2];
    assign n  = {1'b0, pend_cnt_reg} + 3'd1;

    assign len0   = seq_len(b0);
    assign full0  = (len0 != 3'd0) && (len0 <= n);
    assign cp0    = full0 ? decode_cp(len0, b0, b1, b2, data_byte) : {5'd0, REPL_CHAR};
    assign cp_fix = (cp0 > MAX_CP) ? {5'd0, REPL_CHAR} : cp0;
    assign cp_off = cp_fix - SUPP_BASE;

    always_comb
    begin
        buffer_byte   = 1'b0;
        pend_cnt_next = pend_cnt_reg;
        exp_len_next  = exp_len_reg;
        if (is_final_byte)
        begin
            pend_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
        end
        else if (pend_cnt_reg == 2'd0)
        begin
            if (len0 > 3'd1)
            begin
                buffer_byte   = 1'b1;
                pend_cnt_next = 2'd1;
                exp_len_next  = len0;
            end
        end
        else if (n >= exp_len_reg)
        begin
            pend_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
        end
        else
        begin
            buffer_byte   = 1'b1;
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end
    end

    always_comb
    begin
        u0  = REPL_CHAR;
        u1  = REPL_CHAR;
        u2  = REPL_CHAR;
        num = 2'd0;
        if (buffer_byte)
        begin
            num = 2'd0;
        end
        else if (full0 || !is_final_byte)
        begin
            if (cp_fix[20:16] != 5'd0)
            begin
                u0  = {HI_SURR_TOP, cp_off[19:10]};
                u1  = {LO_SURR_TOP, cp_off[9:0]};
                num = 2'd2;
            end
            else
            begin
                u0  = cp_fix[15:0];
                num = 2'd1;
            end
        end
        else
        begin
            // truncated or invalid lead at end of text, the rest is decoded again
            case (n)
                3'd1:
                begin
                    num = 2'd1;
                end
                3'd2:
                begin
                    u1  = b1[7] ? REPL_CHAR : {8'd0, b1};
                    num = 2'd2;
                end
                default:
                begin
                    if (seq_len(b1) == 3'd2)
                    begin
                        u1  = {5'd0, b1[4:0], b2[5:0]};
                        num = 2'd2;
                    end
                    else
                    begin
                        u1  = b1[7] ? REPL_CHAR : {8'd0, b1};
                        u2  = b2[7] ? REPL_CHAR : {8'd0, b2};
                        num = 2'd3;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            exp_len_reg  <= 3'd0;
        end
        else if (in_take)
        begin
            pend_cnt_reg <= pend_cnt_next;
            exp_len_reg  <= exp_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && buffer_byte)
        begin
            case (pend_cnt_reg)
                2'd0:    pend_reg[0] <= data_byte;
                2'd1:    pend_reg[1] <= data_byte;
                2'd2:    pend_reg[2] <= data_byte;
                default: pend_reg[2] <= data_byte;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg   <= 2'd0;
            res_final_reg <= 1'b0;
        end
        else if (in_take)
        begin
            res_cnt_reg   <= num;
            res_final_reg <= is_final_byte;
        end
        else if (out_take)
        begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_reg[0] <= u0;
            res_reg[1] <= u1;
            res_reg[2] <= u2;
        end
        else if (out_take)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

`ifndef SYNTHESIS
    a_take_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && out_take))
        else $error("item taken while results still pending");

    a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg != 2'd0) |-> ({1'b0, pend_cnt_reg} < exp_len_reg))
        else $error("buffered count reached sequence length");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && is_final_byte) |=> (pend_cnt_reg == 2'd0) && (res_cnt_reg != 2'd0))
        else $error("final byte left state or gave no unit");

    a_eot_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && end_of_text) |-> last_of_run)
        else $error("end of text not on last unit");
`endif

endmodule

@@ dv/utf8_to_utf16_transcoder_top_tb.sv @@
module utf8_to_utf16_transcoder_top_tb;
    import u8u16_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 440;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    localparam byte_t LEAD_MASK [5]  = '{8'h00, 8'h7f, 8'h1f, 8'h0f, 8'h07};
    localparam int    TAIL_SHIFT [5] = '{0, 18, 12, 6, 0};
    localparam byte_t CONT_BITS      = 8'h3f;
    localparam unit_t HIGH_HALF_BASE = 16'hd800;
    localparam unit_t LOW_HALF_BASE  = 16'hdc00;

    typedef struct packed {
        unit_t code;
        logic  last;
        logic  eot;
    } unit_rec_t;

    class u16_unit_board;
        byte_t     held_bytes [3];
        count_t    held_count;
        len_t      want_len;
        unit_t     step_units [$];
        unit_rec_t awaited_units [$];
        int        errors;

        function new();
            held_bytes = '{default: 8'h00};
            held_count = '0;
            want_len   = '0;
            errors     = 0;
        endfunction

        function int lead_length(byte_t lead);
            casez (lead[7:3])
                5'b0????: return 1;
                5'b110??: return 2;
                5'b1110?: return 3;
                5'b11110: return 4;
                default:  return 0;
            endcase
        endfunction

        // returns the number of bytes the sequence at pos consumes
        function int decode_at(byte_t seq [4], int pos, int n, output bit [31:0] cp);
            byte_t    lead;
            int       len;
            bit [31:0] v;
            lead = seq[pos & 3];
            len  = lead_length(lead);
            if (len == 0 || pos + len > n)
            begin
                cp = 32'(REPL_CHAR);
                return 1;
            end
            v = 32'(lead & LEAD_MASK[len]) << 18;
            if (len >= 2)
            begin
                v |= 32'(seq[(pos + 1) & 3] & CONT_BITS) << 12;
            end
            if (len >= 3)
            begin
                v |= 32'(seq[(pos + 2) & 3] & CONT_BITS) << 6;
            end
            if (len >= 4)
            begin
                v |= 32'(seq[(pos + 3) & 3] & CONT_BITS);
            end
            cp = v >> TAIL_SHIFT[len];
            return len;
        endfunction

        function void put_unit(unit_t u);
            if (step_units.size() < 3)
            begin
                step_units.push_back(u);
            end
        endfunction

        function void add_code_point(bit [31:0] cp);
            bit [31:0] off;
            if (cp > 32'(MAX_CP))
            begin
                cp = 32'(REPL_CHAR);
            end
            if (cp < 32'(SUPP_BASE))
            begin
                put_unit(cp[15:0]);
            end
            else
            begin
                off = cp - 32'(SUPP_BASE);
                put_unit(16'(off >> 10) + HIGH_HALF_BASE);
                put_unit(16'(off & 32'h3ff) + LOW_HALF_BASE);
            end
        endfunction

        function void take_byte(byte_t b, bit fin);
            byte_t     seq [4];
            int        n;
            int        pos;
            int        len;
            bit [31:0] cp;
            unit_rec_t rec;
            step_units.delete();
            seq = '{default: 8'h00};
            for (int i = 0; i < int'(held_count); i++)
            begin
                seq[i] = held_bytes[i];
            end
            seq[held_count] = b;
            n = int'(held_count) + 1;
            if (fin)
            begin
                pos = 0;
                while (pos < n)
                begin
                    pos += decode_at(seq, pos, n, cp);
                    add_code_point(cp);
                end
                held_count = '0;
                want_len   = '0;
            end
            else if (held_count == 0)
            begin
                len = lead_length(b);
                if (len <= 1)
                begin
                    void'(decode_at(seq, 0, 1, cp));
                    add_code_point(cp);
                end
                else
                begin
                    held_bytes[0] = b;
                    held_count    = 2'd1;
                    want_len      = len_t'(len);
                end
            end
            else if (n >= int'(want_len))
            begin
                void'(decode_at(seq, 0, n, cp));
                add_code_point(cp);
                held_count = '0;
                want_len   = '0;
            end
            else
            begin
                held_bytes[int'(held_count) % 3] = b;
                held_count = held_count + 2'd1;
            end
            foreach (step_units[i])
            begin
                rec.code = step_units[i];
                rec.last = (i == step_units.size() - 1);
                rec.eot  = fin && rec.last;
                awaited_units.push_back(rec);
            end
        endfunction

        function void check_unit(unit_t code, logic last, logic eot);
            unit_rec_t want;
            if (awaited_units.size() == 0)
            begin
                $display("%0t: unexpected code unit %h last_of_run %b end_of_text %b",
                         $time, code, last, eot);
                errors++;
                return;
            end
            want = awaited_units.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: code_unit expected %h actual %h", $time, want.code, code);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                errors++;
            end
            if (eot !== want.eot)
            begin
                $display("%0t: end_of_text expected %b actual %b", $time, want.eot, eot);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  data_byte;
    logic        is_final_byte;
    logic        unit_valid;
    logic        unit_stall;
    logic [15:0] code_unit;
    logic        last_of_run;
    logic        end_of_text;

    u16_unit_board board;
    logic          quiet;
    int            send_odds;
    int            cycle_count;

    utf8_to_utf16_transcoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .is_final_byte (is_final_byte),
        .unit_valid    (unit_valid),
        .unit_stall    (unit_stall),
        .code_unit     (code_unit),
        .last_of_run   (last_of_run),
        .end_of_text   (end_of_text)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // output side stalls in bursts, with calm stretches
    initial
    begin
        int hold;
        int stall_odds;
        int span;
        hold       = 0;
        stall_odds = 0;
        span       = 0;
        unit_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span = 64;
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 4;
                    default: stall_odds = 12;
                endcase
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                begin
                    unit_stall <= 1'b0;
                end
            end
            else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                unit_stall <= 1'b1;
                hold = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && unit_valid && !unit_stall)
        begin
            board.check_unit(code_unit, last_of_run, end_of_text);
        end
    end

    task automatic send_byte(input byte_t b, input bit fin);
        if (!quiet && send_odds != 0 && $urandom_range(1, send_odds) == 1)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        byte_valid    <= 1'b1;
        data_byte     <= b;
        is_final_byte <= fin;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        board.take_byte(b, fin);
        @(negedge clk);
    endtask

    function automatic byte_t tail_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            return byte_t'($urandom_range(0, 255));
        end
        return {2'b10, 6'($urandom)};
    endfunction

    // one character, mostly well formed, sometimes a stray byte
    function automatic void add_char(ref byte_t txt [$], output int len);
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                txt.push_back(byte_t'($urandom_range(0, 127)));
                len = 1;
            end
            3, 4:
            begin
                txt.push_back({3'b110, 5'($urandom)});
                txt.push_back(tail_byte());
                len = 2;
            end
            5, 6:
            begin
                txt.push_back({4'b1110, 4'($urandom)});
                txt.push_back(tail_byte());
                txt.push_back(tail_byte());
                len = 3;
            end
            7, 8:
            begin
                txt.push_back({5'b11110, 3'($urandom)});
                txt.push_back(tail_byte());
                txt.push_back(tail_byte());
                txt.push_back(tail_byte());
                len = 4;
            end
            default:
            begin
                txt.push_back(byte_t'($urandom_range(0, 255)));
                len = 1;
            end
        endcase
    endfunction

    initial
    begin
        logic [8:0] demo [$];
        byte_t      txt [$];
        int         sent;
        int         chars;
        int         last_len;
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        data_byte     = 8'h00;
        is_final_byte = 1'b0;
        quiet         = 1'b0;
        send_odds     = 4;
        board         = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // bit 8 marks the last byte of a string
        demo = '{9'h000, 9'h07f, 9'h080, 9'h0ff, 9'h0f8,
                 9'h0c2, 9'h0a9,
                 9'h0c0, 9'h080,
                 9'h0ed, 9'h0a0, 9'h080,
                 9'h0f0, 9'h09f, 9'h098, 9'h080,
                 9'h0f4, 9'h090, 9'h080, 9'h080,
                 9'h0f0, 9'h09f, 9'h141,
                 9'h100,
                 9'h0e2, 9'h082, 9'h1ac};
        foreach (demo[i])
        begin
            send_byte(demo[i][7:0], demo[i][8]);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            txt.delete();
            chars = $urandom_range(1, 6);
            repeat (chars) add_char(txt, last_len);
            // sometimes cut the string short inside its last sequence
            if (last_len > 1 && $urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, last_len - 1)) void'(txt.pop_back());
            end
            case ($urandom_range(0, 2))
                0:       send_odds = 0;
                1:       send_odds = 4;
                default: send_odds = 12;
            endcase
            if (sent >= RANDOM_ITEMS - 60)
            begin
                quiet = 1'b1;
            end
            foreach (txt[i])
            begin
                send_byte(txt[i], i == txt.size() - 1);
            end
            sent += txt.size();
        end
        byte_valid <= 1'b0;

        while (board.awaited_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/u8u16_pkg.sv
sv/utf8_to_utf16_transcoder_top.sv
dv/utf8_to_utf16_transcoder_top_tb.sv
